@@ rtl/evst_pkg.sv @@
// Shared types, constants and widths for the energy VAD with silence timeout.
package evst_pkg;

  localparam int SMP_W = 16;
  localparam int RMS_W = 16;
  localparam int RAD_W = 2 * RMS_W;
  localparam int CFG_IDX_W = 2;

  localparam int BLOCK_MAX_DEF = 4096;
  localparam int CAL_MAX_DEF = 1024;
  localparam int START_DELAY_DEF = 200;

  localparam logic [RMS_W-1:0] CAL_OFFSET = 16'd500;
  localparam logic [15:0] THRESHOLD_RST = 16'd500;
  localparam logic [15:0] SIL_TICKS_RST = 16'd1000;
  localparam logic [15:0] CAL_TICKS_RST = 16'd3000;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIL_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_TICKS = 2'd2;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_ARM    = 2'd2,
    OP_CAL    = 2'd3
  } evst_op_t;

  typedef enum logic [1:0] {
    KIND_RMS  = 2'd0,
    KIND_STOP = 2'd1,
    KIND_THR  = 2'd2
  } evst_kind_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [SMP_W-1:0] sample;
    logic                    block_end;
  } evst_in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [RMS_W-1:0] value;
  } evst_out_t;

  typedef struct packed {
    logic       load;
    logic       exec;
    logic       div_start;
    logic       div_cal;
    logic       sqrt_start;
    logic       emit;
    evst_kind_t emit_kind;
  } evst_cmd_t;

  typedef struct packed {
    evst_op_t op;
    logic     block_close;
    logic     sil_expire;
    logic     cal_end;
    logic     cal_empty;
    logic     div_done;
    logic     sqrt_done;
    logic     out_busy;
  } evst_stat_t;

endpackage

@@ rtl/energy_vad_silence_timeout_top.sv @@
// Top level: RMS energy voice activity detector with silence timeout and calibration.
//
// Input channel (in_valid/in_ready/in_data) carries one request: a sample, a time
// tick, an arm command or a calibration start. Output channel (out_valid/out_ready/
// out_data) carries a block RMS, a silence stop or a calibrated threshold; a
// request yields at most one result. Config channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data) writes threshold, silence ticks and calibration ticks;
// cfg_ready is always high; the user must make writes while the block is idle,
// as the block itself does not enforce this. One request is in flight at a time.
// A block-closing sample goes through a restoring divider producing one quotient
// bit per cycle (quotient width 43 at the default BLOCK_MAX), then a square root
// producing one root bit per cycle. A calibration end with blocks uses the
// divider alone. The result sits in an output register; the next request is
// taken while it waits, and a later result holds in the controller until that
// register frees. Reset (rst, synchronous) restores the register defaults and
// clears every mode, the block accumulator and the output register.
module energy_vad_silence_timeout_top import evst_pkg::*; #(
  parameter int BLOCK_MAX   = BLOCK_MAX_DEF,
  parameter int CAL_MAX     = CAL_MAX_DEF,
  parameter int START_DELAY = START_DELAY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  evst_in_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output evst_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  evst_cmd_t  cmd;
  evst_stat_t stat;

  assign cfg_ready = 1'b1;

  evst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  evst_dp #(
    .BLOCK_MAX   (BLOCK_MAX),
    .CAL_MAX     (CAL_MAX),
    .START_DELAY (START_DELAY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && !out_ready))
    else $error("result written over a pending one");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in flight");

  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_STOP) |-> out_data.value == '0)
    else $error("silence stop carries a nonzero value");
`endif

endmodule

@@ rtl/evst_div.sv @@
// Restoring divider, one quotient bit per cycle.
module evst_div import evst_pkg::*; #(
  parameter int DVD_W = 43,
  parameter int DVS_W = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] q;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  assign rem_sh   = {rem, q[DVD_W-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      q   <= {q[DVD_W-2:0], ge};
      rem <= ge ? DVS_W'(rem_sh - {1'b0, dvs}) : DVS_W'(rem_sh);
    end
  end

endmodule

@@ rtl/evst_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
module evst_sqrt import evst_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [RAD_W-1:0] radicand,
  output logic             done,
  output logic [RMS_W-1:0] root
);

  localparam int CNT_W = $clog2(RMS_W + 1);
  localparam int REM_W = RMS_W + 2;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             ge;

  assign rem_sh = {rem, rad[RAD_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(RMS_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root <= {root[RMS_W-2:0], ge};
    end
  end

endmodule

@@ rtl/evst_dp.sv @@
// Datapath: config registers, block accumulator, timers, calibration, result register.
module evst_dp import evst_pkg::*; #(
  parameter int BLOCK_MAX   = BLOCK_MAX_DEF,
  parameter int CAL_MAX     = CAL_MAX_DEF,
  parameter int START_DELAY = START_DELAY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  evst_in_t             in_data,
  output evst_out_t            out_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  evst_cmd_t            cmd,
  output evst_stat_t           stat
);

  localparam int CNT_W  = $clog2(BLOCK_MAX + 1);
  localparam int SUM_W  = CNT_W + 2 * SMP_W - 2;
  localparam int CALN_W = $clog2(CAL_MAX + 1);
  localparam int TOT_W  = CALN_W + RMS_W - 1;
  localparam int DVD_W  = (SUM_W > TOT_W) ? SUM_W : TOT_W;
  localparam int DVS_W  = (CNT_W > CALN_W) ? CNT_W : CALN_W;

  logic [15:0]        threshold;
  logic [15:0]        sil_ticks;
  logic [15:0]        cal_ticks;
  evst_in_t           item;
  logic [2*SMP_W-1:0] sq;
  logic [SUM_W-1:0]   sum;
  logic [CNT_W-1:0]   count;
  logic               vad_armed;
  logic [15:0]        sil_left;
  logic               sil_running;
  logic [7:0]         arm_left;
  logic               calibrating;
  logic [15:0]        cal_left;
  logic [TOT_W-1:0]   rms_total;
  logic [CALN_W-1:0]  rms_blocks;

  evst_op_t           op;
  logic [SMP_W-1:0]   mag;
  logic [SUM_W-1:0]   sum_new;
  logic [CNT_W-1:0]   count_new;
  logic               block_close;
  logic               sil_expire;
  logic               cal_end;
  logic [DVD_W-1:0]   div_dvd;
  logic [DVS_W-1:0]   div_dvs;
  logic [DVD_W-1:0]   div_q;
  logic               div_done;
  logic [RMS_W-1:0]   root;
  logic               sqrt_done;
  logic [RMS_W:0]     thr_sum;
  logic [RMS_W-1:0]   thr;
  logic [RMS_W-1:0]   emit_value;

  assign op          = evst_op_t'(item.cmd);
  assign mag         = in_data.sample[SMP_W-1] ? SMP_W'(-in_data.sample)
                                               : SMP_W'(in_data.sample);
  assign sum_new     = sum + SUM_W'(sq);
  assign count_new   = count + 1'b1;
  assign block_close = item.block_end || (count_new == CNT_W'(BLOCK_MAX));
  assign sil_expire  = sil_running && (sil_left <= 16'd1);
  assign cal_end     = !sil_expire && calibrating && (cal_left <= 16'd1);

  assign div_dvd = cmd.div_cal ? DVD_W'(rms_total) : DVD_W'(sum_new);
  assign div_dvs = cmd.div_cal ? DVS_W'(rms_blocks) : DVS_W'(count_new);

  assign thr_sum = {1'b0, div_q[RMS_W-1:0]} + {1'b0, CAL_OFFSET};
  assign thr     = thr_sum[RMS_W] ? '1 : thr_sum[RMS_W-1:0];

  always_comb begin
    case (cmd.emit_kind)
      KIND_RMS: emit_value = root;
      KIND_THR: emit_value = (rms_blocks != '0) ? thr : '0;
      default:  emit_value = '0;
    endcase
  end

  assign stat.op          = op;
  assign stat.block_close = block_close;
  assign stat.sil_expire  = sil_expire;
  assign stat.cal_end     = cal_end;
  assign stat.cal_empty   = (rms_blocks == '0);
  assign stat.div_done    = div_done;
  assign stat.sqrt_done   = sqrt_done;
  assign stat.out_busy    = out_valid && !out_ready;

  evst_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  evst_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .radicand (RAD_W'(div_q)),
    .done     (sqrt_done),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
      sq   <= mag * mag;
    end
    if (cmd.emit) begin
      out_data.kind  <= cmd.emit_kind;
      out_data.value <= emit_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= THRESHOLD_RST;
      sil_ticks   <= SIL_TICKS_RST;
      cal_ticks   <= CAL_TICKS_RST;
      sum         <= '0;
      count       <= '0;
      vad_armed   <= 1'b0;
      sil_left    <= '0;
      sil_running <= 1'b0;
      arm_left    <= '0;
      calibrating <= 1'b0;
      cal_left    <= '0;
      rms_total   <= '0;
      rms_blocks  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_THRESHOLD: threshold <= cfg_data;
          CFG_SIL_TICKS: sil_ticks <= cfg_data;
          CFG_CAL_TICKS: cal_ticks <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.exec) begin
        case (op)
          OP_SAMPLE: begin
            if (block_close) begin
              sum   <= '0;
              count <= '0;
            end else begin
              sum   <= sum_new;
              count <= count_new;
            end
          end
          OP_TICK: begin
            if (sil_expire || cal_end) begin
              vad_armed   <= 1'b0;
              sil_running <= 1'b0;
              sil_left    <= '0;
              arm_left    <= '0;
              calibrating <= 1'b0;
              cal_left    <= '0;
            end else begin
              if (sil_running) sil_left <= sil_left - 1'b1;
              if (calibrating) cal_left <= cal_left - 1'b1;
              if (arm_left != '0) begin
                arm_left <= arm_left - 1'b1;
                if (arm_left == 8'd1) begin
                  sil_running <= 1'b1;
                  sil_left    <= sil_ticks;
                end
              end
            end
          end
          OP_ARM: begin
            vad_armed <= 1'b1;
            arm_left  <= 8'(START_DELAY);
            if (START_DELAY == 0) begin
              sil_running <= 1'b1;
              sil_left    <= sil_ticks;
            end
          end
          OP_CAL: begin
            calibrating <= 1'b1;
            rms_total   <= '0;
            rms_blocks  <= '0;
            cal_left    <= cal_ticks;
          end
        endcase
      end

      if (cmd.emit) begin
        out_valid <= 1'b1;
        if (cmd.emit_kind == KIND_RMS) begin
          if (vad_armed && ((root >= threshold) || !sil_running)) begin
            sil_running <= 1'b1;
            sil_left    <= sil_ticks;
          end
          if (calibrating && (rms_blocks < CALN_W'(CAL_MAX))) begin
            rms_total  <= rms_total + TOT_W'(root);
            rms_blocks <= rms_blocks + 1'b1;
          end
        end else if (cmd.emit_kind == KIND_THR && rms_blocks != '0) begin
          threshold <= thr;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/evst_ctrl.sv @@
// Controller: sequences request decode, divide, square root and result hand-off.
module evst_ctrl import evst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  evst_stat_t stat,
  output evst_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_SQRT,
    S_EMIT
  } state_t;

  state_t     state, state_next;
  logic       div_cal, div_cal_next;
  evst_kind_t kind, kind_next;

  always_comb begin
    state_next    = state;
    div_cal_next  = div_cal;
    kind_next     = kind;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.emit_kind = kind;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
        if (stat.op == OP_SAMPLE && stat.block_close) begin
          cmd.div_start = 1'b1;
          div_cal_next  = 1'b0;
          kind_next     = KIND_RMS;
          state_next    = S_DIV;
        end else if (stat.op == OP_TICK && stat.sil_expire) begin
          kind_next  = KIND_STOP;
          state_next = S_EMIT;
        end else if (stat.op == OP_TICK && stat.cal_end) begin
          kind_next = KIND_THR;
          if (stat.cal_empty) begin
            state_next = S_EMIT;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_cal   = 1'b1;
            div_cal_next  = 1'b1;
            state_next    = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          if (div_cal) begin
            state_next = S_EMIT;
          end else begin
            cmd.sqrt_start = 1'b1;
            state_next     = S_SQRT;
          end
        end
      end
      S_SQRT: begin
        if (stat.sqrt_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cal <= 1'b0;
      kind    <= KIND_RMS;
    end else begin
      state   <= state_next;
      div_cal <= div_cal_next;
      kind    <= kind_next;
    end
  end

endmodule

@@ verif/evst_checker.sv @@
// Checker for the energy VAD: predicts block RMS, silence stops and calibrated thresholds.
module evst_checker import evst_pkg::*; #(
  parameter int BLOCK_MAX   = BLOCK_MAX_DEF,
  parameter int CAL_MAX     = CAL_MAX_DEF,
  parameter int START_DELAY = START_DELAY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  evst_in_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  evst_out_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   errors,
  output int                   outstanding
);

  logic [15:0] thr_reg, sil_ticks_reg, cal_ticks_reg;

  longint unsigned sq_acc;
  int unsigned     blk_cnt;
  bit              armed, sil_run, cal_on;
  logic [15:0]     sil_left, cal_left;
  int unsigned     arm_left;
  int unsigned     rms_sum, rms_n;

  evst_out_t pending_results[$];
  int        err_cnt = 0;

  function automatic logic [15:0] floor_sqrt(longint unsigned v);
    longint unsigned root, trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root[15:0];
  endfunction

  task automatic expect_result(evst_kind_t k, logic [15:0] v);
    evst_out_t r;
    r.kind = k;
    r.value = v;
    pending_results = {pending_results, r};
  endtask

  task automatic restart_silence();
    sil_run = 1'b1;
    sil_left = sil_ticks_reg;
  endtask

  task automatic drop_modes();
    armed = 1'b0;
    sil_run = 1'b0;
    sil_left = '0;
    arm_left = 0;
    cal_on = 1'b0;
    cal_left = '0;
  endtask

  task automatic vad_step(input evst_in_t req);
    longint      sq;
    logic [15:0] rms;
    int unsigned thr;
    case (req.cmd)
      OP_SAMPLE: begin
        sq = longint'($signed(req.sample)) * longint'($signed(req.sample));
        sq_acc += sq;
        blk_cnt++;
        if (!req.block_end && blk_cnt < BLOCK_MAX) return;
        rms = floor_sqrt(sq_acc / longint'(blk_cnt));
        sq_acc = 0;
        blk_cnt = 0;
        if (armed) begin
          if (rms >= thr_reg || !sil_run) restart_silence();
        end
        if (cal_on && rms_n < CAL_MAX) begin
          rms_sum += rms;
          rms_n++;
        end
        expect_result(KIND_RMS, rms);
      end
      OP_TICK: begin
        if (sil_run) begin
          if (sil_left <= 1) begin
            drop_modes();
            expect_result(KIND_STOP, 16'd0);
            return;
          end
          sil_left--;
        end
        if (cal_on) begin
          if (cal_left <= 1) begin
            thr = 0;
            if (rms_n != 0) begin
              thr = rms_sum / rms_n + CAL_OFFSET;
              if (thr > 32'hFFFF) thr = 32'hFFFF;
              thr_reg = thr[15:0];
            end
            drop_modes();
            expect_result(KIND_THR, thr[15:0]);
            return;
          end
          cal_left--;
        end
        if (arm_left != 0) begin
          arm_left--;
          if (arm_left == 0) restart_silence();
        end
      end
      OP_ARM: begin
        armed = 1'b1;
        arm_left = START_DELAY & 255;
        if (arm_left == 0) restart_silence();
      end
      default: begin
        cal_on = 1'b1;
        rms_sum = 0;
        rms_n = 0;
        cal_left = cal_ticks_reg;
      end
    endcase
  endtask

  always @(posedge clk) begin
    evst_out_t exp_r;
    if (rst) begin
      thr_reg = THRESHOLD_RST;
      sil_ticks_reg = SIL_TICKS_RST;
      cal_ticks_reg = CAL_TICKS_RST;
      sq_acc = 0;
      blk_cnt = 0;
      rms_sum = 0;
      rms_n = 0;
      drop_modes();
      pending_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_THRESHOLD: thr_reg = cfg_data;
          CFG_SIL_TICKS: sil_ticks_reg = cfg_data;
          CFG_CAL_TICKS: cal_ticks_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with none expected: kind %0d value %0d",
                 out_data.kind, out_data.value);
          err_cnt++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_data.kind !== exp_r.kind) begin
            $error("kind: expected %0d, got %0d", exp_r.kind, out_data.kind);
            err_cnt++;
          end
          if (out_data.value !== exp_r.value) begin
            $error("value: expected %0d, got %0d", exp_r.value, out_data.value);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) vad_step(in_data);
    end
    errors <= err_cnt;
    outstanding <= pending_results.size();
  end

endmodule

@@ verif/energy_vad_silence_timeout_top_tb.sv @@
// Testbench top for the energy VAD: clock, reset, request and config stimulus, verdict.
module energy_vad_silence_timeout_top_tb;
  import evst_pkg::*;

  localparam int RAND_ITEMS = 1650;
  localparam int SETTLE = 100;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  evst_in_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  evst_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_THRESHOLD;
  logic [15:0]          cfg_data = '0;

  int errors;
  int outstanding;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int rx_wait = 0;
  int rx_stall;

  energy_vad_silence_timeout_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  evst_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stall after every accepted result, none while rx_quiet is set
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else if (out_valid && out_ready) begin
      rx_stall = rx_quiet ? 0 : $urandom_range(0, 17);
      rx_wait <= rx_stall;
      out_ready <= (rx_stall == 0);
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic push_req(input evst_op_t op, input logic [15:0] smp, input logic be);
    evst_in_t req;
    int       gap;
    req.cmd = op;
    req.sample = smp;
    req.block_end = be;
    gap = tx_quiet ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] thr, input logic [15:0] sil,
                          input logic [15:0] cal);
    cfg_write(CFG_THRESHOLD, thr);
    cfg_write(CFG_SIL_TICKS, sil);
    cfg_write(CFG_CAL_TICKS, cal);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_ticks();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'hFFFF;
    if (r < 10) return 16'($urandom_range(1, 12));
    return 16'($urandom_range(1, 40));
  endfunction

  initial begin
    int          rand_items;
    int          n;
    int          pick;
    int          amp;
    logic [15:0] smp;
    logic        be;
    logic [15:0] thr;
    rand_items = 0;
    amp = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // zero calibration ticks act as a single tick; also an unused config index and extreme samples
    cfg_write(CFG_UNUSED, 16'hA5A5);
    set_regs(16'd100, 16'd0, 16'd0);
    push_req(OP_SAMPLE, 16'h7FFF, 1'b1);
    push_req(OP_SAMPLE, 16'h8000, 1'b1);
    push_req(OP_SAMPLE, 16'd3, 1'b0);
    push_req(OP_SAMPLE, 16'hFFFC, 1'b1);
    push_req(OP_TICK, 16'hFFFF, 1'b1);
    push_req(OP_CAL, 16'h0000, 1'b0);
    push_req(OP_TICK, 16'h0000, 1'b0);
    push_req(OP_ARM, 16'h1234, 1'b0);
    push_req(OP_SAMPLE, 16'd5, 1'b1);
    push_req(OP_TICK, 16'h0000, 1'b0);

    // loud block restarts the timer, quiet one does not; stop drops calibration
    wait_idle();
    set_regs(16'd50, 16'd3, 16'd6);
    push_req(OP_CAL, 16'h0000, 1'b0);
    push_req(OP_ARM, 16'h0000, 1'b0);
    push_req(OP_SAMPLE, 16'd1000, 1'b1);
    push_req(OP_SAMPLE, 16'd10, 1'b1);
    push_req(OP_TICK, 16'h0000, 1'b0);
    push_req(OP_SAMPLE, 16'd2000, 1'b1);
    repeat (3) push_req(OP_TICK, 16'h0000, 1'b0);

    // restarted calibration window
    push_req(OP_CAL, 16'h0000, 1'b0);
    push_req(OP_SAMPLE, 16'd300, 1'b1);
    push_req(OP_CAL, 16'h0000, 1'b0);
    push_req(OP_SAMPLE, 16'hFFD8, 1'b1);
    repeat (6) push_req(OP_TICK, 16'h0000, 1'b0);

    // full-size block closes on its own at max amplitude; largest threshold
    wait_idle();
    set_regs(16'd33268, 16'hFFFF, 16'd1);
    tx_quiet = 1'b1;
    push_req(OP_CAL, 16'h0000, 1'b0);
    repeat (BLOCK_MAX_DEF) push_req(OP_SAMPLE, 16'h8000, 1'b0);
    push_req(OP_TICK, 16'h0000, 1'b0);
    push_req(OP_ARM, 16'h0000, 1'b0);
    push_req(OP_SAMPLE, 16'h7FFF, 1'b1);
    push_req(OP_TICK, 16'h0000, 1'b0);

    // arm delay runs out, then the silence timer expires
    wait_idle();
    set_regs(16'd500, 16'd5, 16'd3000);
    tx_quiet = 1'b0;
    push_req(OP_ARM, 16'h0000, 1'b0);
    repeat (210) push_req(OP_TICK, 16'($urandom), 1'($urandom));

    while (rand_items < RAND_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: thr = 16'd0;
        1: thr = 16'd33268;
        2, 3, 4, 5: thr = 16'($urandom_range(0, 2000));
        default: thr = 16'($urandom_range(0, 33268));
      endcase
      set_regs(thr, pick_ticks(), pick_ticks());
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      amp = $urandom_range(0, 3);
      if ($urandom_range(0, 1)) push_req(OP_ARM, 16'($urandom), 1'($urandom));
      if ($urandom_range(0, 1)) push_req(OP_CAL, 16'($urandom), 1'($urandom));
      n = $urandom_range(40, 160);
      for (int k = 0; k < n; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          case (amp)
            0: smp = 16'($urandom);
            1: smp = 16'($urandom_range(0, 64));
            2: smp = 16'($urandom_range(0, 3000));
            default: smp = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
          endcase
          if ((amp == 1 || amp == 2) && $urandom_range(0, 1)) smp = -smp;
          be = ($urandom_range(0, 3) == 0);
          push_req(OP_SAMPLE, smp, be);
          if (be) amp = $urandom_range(0, 3);
        end else if (pick < 92) begin
          push_req(OP_TICK, 16'($urandom), 1'($urandom));
        end else if (pick < 96) begin
          push_req(OP_ARM, 16'($urandom), 1'($urandom));
        end else begin
          push_req(OP_CAL, 16'($urandom), 1'($urandom));
        end
      end
      rand_items += n;
    end

    wait_idle();
    if (errors == 0) begin
      $display("energy_vad_silence_timeout_top_tb passed");
    end else begin
      $display("energy_vad_silence_timeout_top_tb failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("energy_vad_silence_timeout_top_tb failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/evst_pkg.sv
rtl/evst_div.sv
rtl/evst_sqrt.sv
rtl/evst_dp.sv
rtl/evst_ctrl.sv
rtl/energy_vad_silence_timeout_top.sv
verif/evst_checker.sv
verif/energy_vad_silence_timeout_top_tb.sv
